### rtl/core/hms_pkg.sv
// Shared types and request codes for the 12/24-hour time-of-day clock.
// No dependencies; imported by the step logic, the top level and the checker.

package hms_pkg;

	// request codes carried in req_type; the fourth code leaves the time unchanged
	localparam logic [1:0] REQ_TICK   = 2'd0;
	localparam logic [1:0] REQ_SET    = 2'd1;
	localparam logic [1:0] REQ_SELECT = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic       new_mode_24h;
		logic [3:0] hour_tens;
		logic [3:0] hour_units;
		logic [3:0] minute_tens;
		logic [3:0] minute_units;
		logic [3:0] second_tens;
		logic [3:0] second_units;
		logic       set_am;
	} req_t;

	typedef struct packed {
		logic [1:0] hours_tens_out;
		logic [3:0] hours_units_out;
		logic [2:0] minutes_tens_out;
		logic [3:0] minutes_units_out;
		logic [2:0] seconds_tens_out;
		logic [3:0] seconds_units_out;
		logic       am_out;
		logic       mode_24h_out;
	} rsp_t;

	typedef struct packed {
		logic [5:0] seconds;
		logic [5:0] minutes;
		logic [4:0] hours;
		logic       mode_24h;
		logic       am;
	} time_state_t;

endpackage

### rtl/core/hms_clock_12_24_hour.sv
// Top level of the 12/24-hour time-of-day clock: input register, time state, result register.
// Depends on hms_pkg and hms_step.
// An accepted transaction passes through the input register and then the result register.
// Throughput: 1 transaction per cycle unless the result is stalled; the time state updates as
// each transaction leaves the input register, in the same cycle its result is loaded.
// Reset (arst_n low): 12:00:00 PM, twelve-hour mode, both registers empty.

module hms_clock_12_24_hour import hms_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam logic [4:0] HOURS_RESET = 5'd12;

	logic        valid_s1;
	req_t        req_s1;
	time_state_t state_q;
	time_state_t state_next;
	rsp_t        rsp_next;
	rsp_t        rsp_q;
	logic        rsp_valid_q;
	logic        advance;
	logic        take_s1;

	// result slot frees when empty or being taken
	assign advance   = !rsp_valid_q || !rsp_stall;
	assign take_s1   = valid_s1 && advance;
	assign req_stall = valid_s1 && !advance;

	hms_step u_step (
		.cur (state_q),
		.req (req_s1),
		.nxt (state_next),
		.rsp (rsp_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.seconds  <= 6'd0;
			state_q.minutes  <= 6'd0;
			state_q.hours    <= HOURS_RESET;
			state_q.mode_24h <= 1'b0;
			state_q.am       <= 1'b0;
			rsp_valid_q      <= 1'b0;
		end else begin
			if (take_s1) begin
				state_q <= state_next;
			end
			if (advance) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### rtl/core/hms_step.sv
// Next-state and BCD result logic for one clock transaction.
// Depends on hms_pkg for the request, result and time-state types.

module hms_step import hms_pkg::*; (
	input  time_state_t cur,
	input  req_t        req,
	output time_state_t nxt,
	output rsp_t        rsp
);

	localparam logic [5:0] MIN_SEC_WRAP = 6'd60;
	localparam logic [4:0] HOUR_NOON    = 5'd12;
	localparam logic [4:0] HOUR_WRAP_12 = 5'd13;
	localparam logic [4:0] HOUR_WRAP_24 = 5'd24;
	localparam logic [7:0] SET_MAX_12   = 8'd12;
	localparam logic [7:0] SET_MAX_24   = 8'd23;
	localparam logic [7:0] SET_MAX_MS   = 8'd59;

	// tens*10 + units, digits up to 15 each
	function automatic logic [7:0] pair_value(input logic [3:0] tens, input logic [3:0] units);
		logic [7:0] t;
		t = {4'd0, tens};
		return (t << 3) + (t << 1) + {4'd0, units};
	endfunction

	// split 0..59 into {tens, units}
	function automatic logic [6:0] split_bcd(input logic [5:0] v);
		logic [2:0] tens;
		logic [5:0] t6;
		logic [5:0] rem;
		if (v >= 6'd50)      tens = 3'd5;
		else if (v >= 6'd40) tens = 3'd4;
		else if (v >= 6'd30) tens = 3'd3;
		else if (v >= 6'd20) tens = 3'd2;
		else if (v >= 6'd10) tens = 3'd1;
		else                 tens = 3'd0;
		t6  = {3'd0, tens};
		rem = v - ((t6 << 3) + (t6 << 1));
		return {tens, rem[3:0]};
	endfunction

	logic [5:0] tk_sec, tk_min;
	logic [4:0] tk_hr;
	logic       tk_am;
	logic [7:0] set_h, set_m, set_s;
	logic [6:0] hr_bcd, min_bcd, sec_bcd;

	always_comb begin
		// tick path: carry seconds into minutes into hours
		tk_sec = cur.seconds + 6'd1;
		tk_min = cur.minutes;
		tk_hr  = cur.hours;
		if (tk_sec >= MIN_SEC_WRAP) begin
			tk_sec = 6'd0;
			tk_min = cur.minutes + 6'd1;
		end
		if (tk_min >= MIN_SEC_WRAP) begin
			tk_min = 6'd0;
			tk_hr  = cur.hours + 5'd1;
		end
		tk_am = cur.am;
		if (!cur.mode_24h) begin
			if (tk_hr >= HOUR_WRAP_12)
				tk_hr = 5'd1;
			if (tk_hr == HOUR_NOON && tk_min == 6'd0 && tk_sec == 6'd0)
				tk_am = ~cur.am;
		end else begin
			if (tk_hr >= HOUR_WRAP_24)
				tk_hr = 5'd0;
			tk_am = (tk_hr < HOUR_NOON);
		end

		set_h = pair_value(req.hour_tens, req.hour_units);
		set_m = pair_value(req.minute_tens, req.minute_units);
		set_s = pair_value(req.second_tens, req.second_units);

		nxt = cur;
		case (req.req_type)
			REQ_TICK: begin
				nxt.seconds = tk_sec;
				nxt.minutes = tk_min;
				nxt.hours   = tk_hr;
				nxt.am      = tk_am;
			end
			REQ_SET: begin
				nxt.mode_24h = req.new_mode_24h;
				if (!req.new_mode_24h) begin
					if (set_h > SET_MAX_12 || set_h == 8'd0)
						set_h = SET_MAX_12;
					nxt.am = req.set_am;
				end else begin
					if (set_h > SET_MAX_24)
						set_h = 8'd0;
					nxt.am = (set_h < SET_MAX_12);
				end
				nxt.hours   = set_h[4:0];
				nxt.minutes = (set_m > SET_MAX_MS) ? 6'd0 : set_m[5:0];
				nxt.seconds = (set_s > SET_MAX_MS) ? 6'd0 : set_s[5:0];
			end
			REQ_SELECT: begin
				// convert only on an actual mode change
				if (req.new_mode_24h != cur.mode_24h) begin
					if (!req.new_mode_24h) begin
						if (cur.hours > HOUR_NOON)
							nxt.hours = cur.hours - HOUR_NOON;
						else if (cur.hours == 5'd0)
							nxt.hours = HOUR_NOON;
					end else begin
						if (cur.am) begin
							if (cur.hours == HOUR_NOON)
								nxt.hours = 5'd0;
						end else if (cur.hours != HOUR_NOON) begin
							nxt.hours = cur.hours + HOUR_NOON;
						end
					end
					nxt.mode_24h = req.new_mode_24h;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase

		hr_bcd  = split_bcd({1'b0, nxt.hours});
		min_bcd = split_bcd(nxt.minutes);
		sec_bcd = split_bcd(nxt.seconds);

		rsp.hours_tens_out    = hr_bcd[5:4];
		rsp.hours_units_out   = hr_bcd[3:0];
		rsp.minutes_tens_out  = min_bcd[6:4];
		rsp.minutes_units_out = min_bcd[3:0];
		rsp.seconds_tens_out  = sec_bcd[6:4];
		rsp.seconds_units_out = sec_bcd[3:0];
		rsp.am_out            = nxt.am;
		rsp.mode_24h_out      = nxt.mode_24h;
	end

	logic unused_hr_msb;
	assign unused_hr_msb = hr_bcd[6];

endmodule

### rtl/core/hms_checker.sv
// Port-level checks for the 12/24-hour clock, bound to the top level.
// Depends on hms_pkg and hms_clock_12_24_hour.

module hms_checker import hms_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	// twelve-hour mode shows hours 1..12 only
	a_hour_12h: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.mode_24h_out |->
			(rsp.hours_tens_out == 2'd0 && rsp.hours_units_out != 4'd0 &&
			 rsp.hours_units_out <= 4'd9) ||
			(rsp.hours_tens_out == 2'd1 && rsp.hours_units_out <= 4'd2))
		else $error("hour out of range in twelve-hour mode");

	// twenty-four-hour mode shows 0..23 and AM agrees with the hour
	a_hour_24h: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.mode_24h_out |->
			((rsp.hours_tens_out < 2'd2 && rsp.hours_units_out <= 4'd9) ||
			 (rsp.hours_tens_out == 2'd2 && rsp.hours_units_out <= 4'd3)) &&
			(rsp.am_out == (rsp.hours_tens_out == 2'd0 ||
			 (rsp.hours_tens_out == 2'd1 && rsp.hours_units_out <= 4'd1))))
		else $error("hour or AM flag wrong in twenty-four-hour mode");

	a_min_sec: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |->
			rsp.minutes_tens_out <= 3'd5 && rsp.minutes_units_out <= 4'd9 &&
			rsp.seconds_tens_out <= 3'd5 && rsp.seconds_units_out <= 4'd9)
		else $error("minutes or seconds digits out of range");

endmodule

bind hms_clock_12_24_hour hms_checker u_hms_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

### tb/sv/hms_clock_12_24_hour_tb.sv
// Self-checking bench for the 12/24-hour time-of-day clock: directed and random transactions,
// with each response checked against a timekeeping predictor in a small scoreboard class.
// Depends on hms_pkg and the hms_clock_12_24_hour top level.

import hms_pkg::*;

class clock_scoreboard;
	rsp_t        expected_q[$];
	int          errors;
	int unsigned secs;
	int unsigned mins;
	int unsigned hrs;
	bit          mode24;
	bit          am;

	function new();
		secs   = 0;
		mins   = 0;
		hrs    = 12;
		mode24 = 1'b0;
		am     = 1'b0;
		errors = 0;
	endfunction

	function void advance_second();
		secs++;
		if (secs >= 60) begin
			secs = 0;
			mins++;
		end
		if (mins >= 60) begin
			mins = 0;
			hrs++;
		end
		if (!mode24) begin
			if (hrs >= 13)
				hrs = 1;
			// noon and midnight flip the meridiem
			if (hrs == 12 && mins == 0 && secs == 0)
				am = ~am;
		end else begin
			if (hrs >= 24)
				hrs = 0;
			am = (hrs < 12);
		end
	endfunction

	function void load_time(req_t item);
		int unsigned h;
		int unsigned m;
		int unsigned s;
		h = item.hour_tens * 10 + item.hour_units;
		m = item.minute_tens * 10 + item.minute_units;
		s = item.second_tens * 10 + item.second_units;
		mode24 = item.new_mode_24h;
		if (!mode24) begin
			if (h > 12 || h == 0)
				h = 12;
			am = item.set_am;
		end else begin
			if (h > 23)
				h = 0;
			am = (h < 12);
		end
		hrs  = h;
		mins = (m > 59) ? 0 : m;
		secs = (s > 59) ? 0 : s;
	endfunction

	function void switch_mode(bit want);
		if (want == mode24)
			return;
		if (!want) begin
			if (hrs > 12)
				hrs -= 12;
			else if (hrs == 0)
				hrs = 12;
		end else begin
			// 12 PM stays 12; 12 AM becomes 0
			if (am) begin
				if (hrs == 12)
					hrs = 0;
			end else if (hrs != 12) begin
				hrs += 12;
			end
		end
		mode24 = want;
	endfunction

	function void note_request(req_t item);
		rsp_t digits;
		case (item.req_type)
			REQ_TICK:   advance_second();
			REQ_SET:    load_time(item);
			REQ_SELECT: switch_mode(item.new_mode_24h);
			default: ;
		endcase
		digits.hours_tens_out    = 2'(hrs / 10);
		digits.hours_units_out   = 4'(hrs % 10);
		digits.minutes_tens_out  = 3'(mins / 10);
		digits.minutes_units_out = 4'(mins % 10);
		digits.seconds_tens_out  = 3'(secs / 10);
		digits.seconds_units_out = 4'(secs % 10);
		digits.am_out            = am;
		digits.mode_24h_out      = mode24;
		expected_q.push_back(digits);
	endfunction

	task report(string msg);
		if (errors < 50)
			$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task check_field(string name, logic [3:0] got, logic [3:0] want);
		if (got !== want)
			report($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	task check_response(rsp_t got);
		rsp_t want;
		if (expected_q.size() == 0) begin
			report("response with no transaction outstanding");
			return;
		end
		want = expected_q.pop_front();
		check_field("hours_tens", got.hours_tens_out, want.hours_tens_out);
		check_field("hours_units", got.hours_units_out, want.hours_units_out);
		check_field("minutes_tens", got.minutes_tens_out, want.minutes_tens_out);
		check_field("minutes_units", got.minutes_units_out, want.minutes_units_out);
		check_field("seconds_tens", got.seconds_tens_out, want.seconds_tens_out);
		check_field("seconds_units", got.seconds_units_out, want.seconds_units_out);
		check_field("am", got.am_out, want.am_out);
		check_field("mode_24h", got.mode_24h_out, want.mode_24h_out);
	endtask

	function int pending();
		return expected_q.size();
	endfunction
endclass

module hms_clock_12_24_hour_tb;
	import hms_pkg::*;

	localparam logic [1:0] REQ_UNUSED   = 2'd3;
	localparam int         CYCLE_LIMIT  = 200000;
	localparam int         DRAIN_CYCLES = 8;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	req_t req       = '0;
	logic rsp_stall = 1'b0;
	logic req_stall;
	logic rsp_valid;
	rsp_t rsp;

	int send_idle   = 0;
	int recv_idle   = 0;
	int hold_cycles = 0;
	int cycle_count = 0;
	int items_sent  = 0;

	clock_scoreboard board = new();

	hms_clock_12_24_hour u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// note each accepted transaction before checking responses of the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				board.note_request(req);
			if (rsp_valid && !rsp_stall)
				board.check_response(rsp);
		end
	end

	// hold off for a counted stretch when asked, else stall at random
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			rsp_stall <= 1'b1;
			hold_cycles--;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < recv_idle);
		end
	end

	function automatic req_t make_req(logic [1:0] kind, bit m24, int ht, int hu, int mt, int mu,
			int st, int su, bit am_sel);
		req_t r;
		r.req_type     = kind;
		r.new_mode_24h = m24;
		r.hour_tens    = 4'(ht);
		r.hour_units   = 4'(hu);
		r.minute_tens  = 4'(mt);
		r.minute_units = 4'(mu);
		r.second_tens  = 4'(st);
		r.second_units = 4'(su);
		r.set_am       = am_sel;
		return r;
	endfunction

	function automatic req_t random_req(logic [1:0] kind);
		req_t        r;
		logic [31:0] raw;
		raw        = $urandom;
		r          = raw[$bits(req_t)-1:0];
		r.req_type = kind;
		return r;
	endfunction

	task automatic drive_item(input req_t item);
		while ($urandom_range(0, 99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (req_stall !== 1'b0)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_set(input bit m24, input int h, input int m, input int s,
			input bit am_sel);
		drive_item(make_req(REQ_SET, m24, h / 10, h % 10, m / 10, m % 10, s / 10, s % 10,
			am_sel));
	endtask

	task automatic send_tick();
		drive_item(random_req(REQ_TICK));
	endtask

	task automatic send_select(input bit m24);
		req_t r;
		r              = random_req(REQ_SELECT);
		r.new_mode_24h = m24;
		drive_item(r);
	endtask

	// drop valid and wait for every outstanding response
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic run_random(input int count);
		int target;
		bit m24;
		int h;
		int m;
		int s;
		int pick;
		target = items_sent + count;
		while (items_sent < target) begin
			if ($urandom_range(0, 9) < 7) begin
				// load a time near a rollover, then run it forward
				m24 = $urandom_range(0, 1);
				case ($urandom_range(0, 2))
					0:       h = 11;
					1:       h = m24 ? 23 : 12;
					default: h = m24 ? $urandom_range(0, 23) : $urandom_range(1, 12);
				endcase
				m = $urandom_range(0, 1) ? 59 : $urandom_range(0, 59);
				s = $urandom_range(0, 1) ? $urandom_range(50, 59) : $urandom_range(0, 59);
				send_set(m24, h, m, s, $urandom_range(0, 1));
				repeat ($urandom_range(1, 12)) begin
					pick = $urandom_range(0, 19);
					if (pick < 16)
						send_tick();
					else if (pick < 19)
						send_select($urandom_range(0, 1));
					else
						drive_item(random_req(REQ_UNUSED));
				end
			end else begin
				drive_item(random_req(2'($urandom_range(0, 3))));
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 17;
		recv_idle = 63;
		send_tick();
		send_select(1'b1);
		send_select(1'b1);
		send_select(1'b0);
		send_select(1'b0);
		send_set(1'b0, 11, 59, 59, 1'b1);
		send_tick();
		send_set(1'b0, 12, 59, 59, 1'b0);
		send_tick();
		send_set(1'b0, 0, 30, 30, 1'b1);
		drive_item(make_req(REQ_SET, 1'b0, 15, 15, 15, 15, 15, 15, 1'b1));
		send_set(1'b0, 13, 0, 0, 1'b0);
		send_set(1'b1, 23, 59, 59, 1'b0);
		send_tick();
		drive_item(make_req(REQ_SET, 1'b1, 9, 9, 6, 0, 5, 9, 1'b1));
		send_set(1'b1, 24, 0, 0, 1'b1);
		send_set(1'b1, 0, 0, 0, 1'b0);
		send_select(1'b0);
		send_select(1'b1);
		send_set(1'b1, 13, 15, 45, 1'b1);
		send_select(1'b0);
		send_set(1'b0, 5, 10, 20, 1'b0);
		send_select(1'b1);
		send_set(1'b1, 11, 59, 59, 1'b0);
		send_tick();
		drive_item(random_req(REQ_UNUSED));
		wait_drained();

		// long receiver hold-off while the sender keeps offering
		hold_cycles = 60;
		run_random(300);
		wait_drained();

		send_idle   = 63;
		recv_idle   = 17;
		hold_cycles = 60;
		run_random(150);
		wait_drained();
		run_random(150);
		wait_drained();

		send_idle = 0;
		recv_idle = 0;
		run_random(300);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
